// ----- rtl/kwt_pkg.sv -----
`default_nettype none
package kwt_pkg;

	localparam int KEY_W          = 48;
	localparam int KEY_BYTES      = KEY_W / 8;
	localparam int FUNC_W         = 3;
	localparam int SCORE_W        = 24;
	localparam int ENTRIES_DEF    = 256;
	localparam int COUNT_BITS_DEF = 16;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD    = 3'd0,
		FN_SEARCH = 3'd1,
		FN_ZERO   = 3'd2,
		FN_SCORE  = 3'd3,
		FN_CLEAR  = 3'd4
	} kwt_func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ZERO,
		ST_DONE
	} kwt_state_t;

	// per-array write enables into the entry store
	typedef struct packed {
		logic key;
		logic weight;
		logic occ;
	} kwt_wr_en_t;

	// key ends at its first zero byte; everything after reads as zero
	function automatic logic [KEY_W-1:0] clip_key(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] res;
		logic             live;
		res  = '0;
		live = 1'b1;
		for (int b = KEY_BYTES - 1; b >= 0; b--) begin
			if (k[8*b +: 8] == 8'h00) live = 1'b0;
			if (live) res[8*b +: 8] = k[8*b +: 8];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/kwt_req_if.sv -----
`default_nettype none
interface kwt_req_if;
	logic                       valid;
	logic                       ready;
	logic [kwt_pkg::FUNC_W-1:0] func;
	logic [kwt_pkg::KEY_W-1:0]  key;

	modport source (output valid, func, key, input ready);
	modport sink   (input valid, func, key, output ready);
endinterface
`default_nettype wire

// ----- rtl/kwt_rsp_if.sv -----
`default_nettype none
interface kwt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic                        table_full;
	logic [kwt_pkg::SCORE_W-1:0] score;

	modport source (output valid, found, table_full, score, input ready);
	modport sink   (input valid, found, table_full, score, output ready);
endinterface
`default_nettype wire

// ----- rtl/kwt_store.sv -----
`default_nettype none
module kwt_store #(
	parameter int ENTRIES    = kwt_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = kwt_pkg::COUNT_BITS_DEF,
	localparam int AW        = $clog2(ENTRIES)
) (
	input  wire logic                      clk,
	input  wire logic [AW-1:0]             raddr,
	output      logic [kwt_pkg::KEY_W-1:0] rd_key,
	output      logic [COUNT_BITS-1:0]     rd_weight,
	output      logic [COUNT_BITS-1:0]     rd_occ,
	input  wire kwt_pkg::kwt_wr_en_t       wen,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [kwt_pkg::KEY_W-1:0] wkey,
	input  wire logic [COUNT_BITS-1:0]     wweight,
	input  wire logic [COUNT_BITS-1:0]     wocc
);

	logic [kwt_pkg::KEY_W-1:0] key_mem    [ENTRIES];
	logic [COUNT_BITS-1:0]     weight_mem [ENTRIES];
	logic [COUNT_BITS-1:0]     occ_mem    [ENTRIES];

	always_ff @(posedge clk) begin
		if (wen.key)    key_mem[waddr]    <= wkey;
		if (wen.weight) weight_mem[waddr] <= wweight;
		if (wen.occ)    occ_mem[waddr]    <= wocc;
	end

	always_ff @(posedge clk) begin
		rd_key    <= key_mem[raddr];
		rd_weight <= weight_mem[raddr];
		rd_occ    <= occ_mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/kwt_unit.sv -----
`default_nettype none
module kwt_unit #(
	parameter int COUNT_BITS = kwt_pkg::COUNT_BITS_DEF
) (
	input  wire logic [kwt_pkg::KEY_W-1:0]   key_ref,
	input  wire logic [kwt_pkg::KEY_W-1:0]   rd_key,
	input  wire logic [COUNT_BITS-1:0]       rd_weight,
	input  wire logic [COUNT_BITS-1:0]       rd_occ,
	input  wire logic                        bump_weight,
	input  wire logic [kwt_pkg::SCORE_W-1:0] acc,
	output      logic                        match,
	output      logic [COUNT_BITS-1:0]       bump_val,
	output      logic [kwt_pkg::SCORE_W-1:0] acc_next
);

	localparam int SW = ((COUNT_BITS > kwt_pkg::SCORE_W) ? COUNT_BITS : kwt_pkg::SCORE_W) + 1;
	localparam logic [SW-1:0] SCORE_MAX = SW'((64'd1 << kwt_pkg::SCORE_W) - 64'd1);

	logic [COUNT_BITS-1:0] src;
	logic [COUNT_BITS-1:0] min_val;
	logic [SW-1:0]         sum;

	assign match = (rd_key == key_ref);

	// saturating increment
	assign src      = bump_weight ? rd_weight : rd_occ;
	assign bump_val = (&src) ? src : src + COUNT_BITS'(1);

	// saturating accumulate of min(occurrence, weight)
	assign min_val  = (rd_occ < rd_weight) ? rd_occ : rd_weight;
	assign sum      = SW'(acc) + SW'(min_val);
	assign acc_next = (sum > SCORE_MAX) ? SCORE_MAX[kwt_pkg::SCORE_W-1:0]
	                                    : sum[kwt_pkg::SCORE_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/keyword_weight_table_unit.sv -----
// Keyword weight table. Requests arrive on req (func, key); one response per
// request leaves on rsp (found, table_full, score). valid/ready handshake on both.
// Entries live in one store with a single read and a single write port; a
// sequencer walks them one per cycle through a shared compare/bump/accumulate unit.
// Work per request, with N entries in the table:
//   add, search, score: walk all N entries (an add or search hit stops early)
//   zero occurrences:   clear the occurrence count of each of the N entries
//   clear, unused codes: no walk, straight to the response
// req.ready is high only while idle, so a new request is not taken until the
// previous one has finished its walk and its result has been loaded.
// The per-entry walk through the single store read port sets how long each takes.
// The response sits in an output register; a new request is taken while it
// waits, and a finished result is held back until the receiver drains it.
// Reset empties the table (entry count zero) and drops any pending response;
// the store itself is not cleared, no clearing pass is needed.
`default_nettype none
module keyword_weight_table_unit #(
	parameter int ENTRIES    = kwt_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = kwt_pkg::COUNT_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	kwt_req_if.sink    req,
	kwt_rsp_if.source  rsp
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	kwt_pkg::kwt_state_t state_q, state_d;
	kwt_pkg::kwt_func_t  func_q, func_d;

	logic [kwt_pkg::KEY_W-1:0]   key_q, key_d;
	logic [CW-1:0]               count_q, count_d;
	logic [CW-1:0]               addr_q, addr_d;
	logic [AW-1:0]               tag_q, tag_d;
	logic                        pend_q, pend_d;
	logic [kwt_pkg::SCORE_W-1:0] acc_q, acc_d;
	logic                        found_q, found_d;
	logic                        full_q, full_d;

	logic                        rsp_valid_q;
	logic                        rsp_found_q;
	logic                        rsp_full_q;
	logic [kwt_pkg::SCORE_W-1:0] rsp_score_q;
	logic                        load_rsp;

	kwt_pkg::kwt_wr_en_t         wen;
	logic [AW-1:0]               waddr;
	logic [kwt_pkg::KEY_W-1:0]   wkey;
	logic [COUNT_BITS-1:0]       wweight;
	logic [COUNT_BITS-1:0]       wocc;

	logic [kwt_pkg::KEY_W-1:0]   rd_key;
	logic [COUNT_BITS-1:0]       rd_weight;
	logic [COUNT_BITS-1:0]       rd_occ;
	logic                        match;
	logic [COUNT_BITS-1:0]       bump_val;
	logic [kwt_pkg::SCORE_W-1:0] acc_next;

	kwt_store #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_store (
		.clk       (clk),
		.raddr     (addr_q[AW-1:0]),
		.rd_key    (rd_key),
		.rd_weight (rd_weight),
		.rd_occ    (rd_occ),
		.wen       (wen),
		.waddr     (waddr),
		.wkey      (wkey),
		.wweight   (wweight),
		.wocc      (wocc)
	);

	kwt_unit #(
		.COUNT_BITS (COUNT_BITS)
	) u_unit (
		.key_ref     (key_q),
		.rd_key      (rd_key),
		.rd_weight   (rd_weight),
		.rd_occ      (rd_occ),
		.bump_weight (func_q == kwt_pkg::FN_ADD),
		.acc         (acc_q),
		.match       (match),
		.bump_val    (bump_val),
		.acc_next    (acc_next)
	);

	always_comb begin
		state_d   = state_q;
		func_d    = func_q;
		key_d     = key_q;
		count_d   = count_q;
		addr_d    = addr_q;
		tag_d     = tag_q;
		pend_d    = 1'b0;
		acc_d     = acc_q;
		found_d   = found_q;
		full_d    = full_q;
		wen       = '0;
		waddr     = tag_q;
		wkey      = key_q;
		wweight   = bump_val;
		wocc      = bump_val;
		load_rsp  = 1'b0;
		req.ready = 1'b0;

		unique case (state_q)
			kwt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					func_d  = kwt_pkg::kwt_func_t'(req.func);
					key_d   = kwt_pkg::clip_key(req.key);
					addr_d  = '0;
					acc_d   = '0;
					found_d = 1'b0;
					full_d  = 1'b0;
					unique case (req.func)
						kwt_pkg::FN_ADD,
						kwt_pkg::FN_SEARCH,
						kwt_pkg::FN_SCORE: state_d = kwt_pkg::ST_SCAN;
						kwt_pkg::FN_ZERO:  state_d = kwt_pkg::ST_ZERO;
						kwt_pkg::FN_CLEAR: begin
							count_d = '0;
							state_d = kwt_pkg::ST_DONE;
						end
						default: state_d = kwt_pkg::ST_DONE;
					endcase
				end
			end

			kwt_pkg::ST_SCAN: begin
				// issue next read; data comes back on the following cycle tagged by tag_q
				if (addr_q < count_q) begin
					pend_d = 1'b1;
					tag_d  = addr_q[AW-1:0];
					addr_d = addr_q + CW'(1);
				end
				if (pend_q) begin
					if (func_q == kwt_pkg::FN_SCORE) begin
						acc_d = acc_next;
					end else if (match) begin
						found_d = 1'b1;
						waddr   = tag_q;
						if (func_q == kwt_pkg::FN_ADD) wen.weight = 1'b1;
						else                           wen.occ    = 1'b1;
						state_d = kwt_pkg::ST_DONE;
					end
				end else if (addr_q == count_q) begin
					// walk finished without a hit
					if (func_q == kwt_pkg::FN_ADD) begin
						if (count_q == CW'(ENTRIES)) begin
							full_d = 1'b1;
						end else begin
							waddr   = count_q[AW-1:0];
							wen     = '{key: 1'b1, weight: 1'b1, occ: 1'b1};
							wweight = COUNT_BITS'(1);
							wocc    = '0;
							count_d = count_q + CW'(1);
						end
					end
					state_d = kwt_pkg::ST_DONE;
				end
			end

			kwt_pkg::ST_ZERO: begin
				if (addr_q < count_q) begin
					wen.occ = 1'b1;
					waddr   = addr_q[AW-1:0];
					wocc    = '0;
					addr_d  = addr_q + CW'(1);
				end else begin
					state_d = kwt_pkg::ST_DONE;
				end
			end

			kwt_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = kwt_pkg::ST_IDLE;
				end
			end

			default: state_d = kwt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kwt_pkg::ST_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			if (load_rsp)       rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		func_q  <= func_d;
		key_q   <= key_d;
		addr_q  <= addr_d;
		tag_q   <= tag_d;
		acc_q   <= acc_d;
		found_q <= found_d;
		full_q  <= full_d;
		if (load_rsp) begin
			rsp_found_q <= found_q;
			rsp_full_q  <= full_q;
			rsp_score_q <= acc_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = rsp_found_q;
	assign rsp.table_full = rsp_full_q;
	assign rsp.score      = rsp_score_q;

endmodule
`default_nettype wire

// ----- rtl/kwt_checker.sv -----
`default_nettype none
module kwt_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic                        rsp_found,
	input wire logic                        rsp_table_full,
	input wire logic [kwt_pkg::SCORE_W-1:0] rsp_score
);

	// response is held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// one request at a time: not ready right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// an add either hits or overflows, never both
	a_found_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_found && rsp_table_full))
		else $error("found and table_full both set");

	// a score only comes with a score request, which reports no hit or overflow
	a_score_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_score != '0) |-> !rsp_found && !rsp_table_full)
		else $error("score with found or table_full");

endmodule

bind keyword_weight_table_unit kwt_checker u_kwt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_found      (rsp.found),
	.rsp_table_full (rsp.table_full),
	.rsp_score      (rsp.score)
);
`default_nettype wire
